>>> rtl/pidsc_pkg.sv
package pidsc_pkg;

  // Field and register widths
  localparam int SPEED_W     = 15;
  localparam int GAIN_W      = 10;
  localparam int DRIVE_W     = 24;
  localparam int CFG_INDEX_W = 2;
  localparam int ERR_W       = 16;  // speed differences, signed

  localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd10;

  // Datapath widths that do not depend on the fraction width
  localparam int PROD_W   = 26;  // speed difference times gain, signed
  localparam int AP_W     = 30;  // e*gain_p - 10*dm*gain_d, signed
  localparam int PMAG_W   = 25;  // magnitude of e*gain_i
  localparam int REM_W    = 7;   // remainders below 125 or 100
  localparam int B_W      = 31;  // biased drive numerator
  localparam int FULL_W   = 27;  // drive before saturation, signed

  // Divide by 125: multiply by floor(2^25/125), correct once
  localparam int INT_DIV    = 125;
  localparam int DIV125_SH  = 25;
  localparam int DIV125_M_W = 19;
  localparam int QA_W       = 19;
  localparam logic [DIV125_M_W-1:0] DIV125_M = DIV125_M_W'((64'd1 << DIV125_SH) / 64'd125);

  // Divide by 100: multiply by floor(2^31/100), correct once
  localparam int DRV_DIV    = 100;
  localparam int DIV100_SH  = 31;
  localparam int DIV100_M_W = 25;
  localparam int QB_W       = 25;
  localparam logic [DIV100_M_W-1:0] DIV100_M = DIV100_M_W'((64'd1 << DIV100_SH) / 64'd100);

  // Bias that keeps the drive numerator positive
  localparam int DRIVE_BIAS_Q = 1 << 23;
  localparam int DRIVE_BIAS   = DRV_DIV * DRIVE_BIAS_Q;

  localparam int INT_LIMIT = 10000;

  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 24'sh7FFFFF;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 24'sh800000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GAIN_P = 2'd0,
    REG_GAIN_I = 2'd1,
    REG_GAIN_D = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [SPEED_W-1:0] target_speed;
    logic [SPEED_W-1:0] measured_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_value;
    logic                      output_saturated;
  } out_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
  } gains_t;

endpackage

>>> rtl/pidsc_front.sv
module pidsc_front #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  pidsc_pkg::in_item_t                        in_data,
  input  pidsc_pkg::gains_t                          gains,
  output logic                                       q_valid,
  input  logic                                       q_ready,
  output logic [FRACTION_BITS+pidsc_pkg::AP_W+16:0]  q_data
);
  import pidsc_pkg::*;

  localparam int F     = FRACTION_BITS;
  localparam int MAG_W = F + 16;
  localparam int SH    = F - 3;
  localparam int R2_W  = F + 4;
  localparam int M2_W  = F - 2;
  localparam logic [M2_W-1:0] M2 = M2_W'((64'd1 << (F + 4)) / 64'd125);

  logic                       en;
  logic [7:1]                 vld_r;
  logic [SPEED_W-1:0]         prev_r;

  logic signed [ERR_W-1:0]    err_nxt, dm_nxt;
  logic signed [ERR_W-1:0]    err1_r, dm1_r;
  logic signed [PROD_W:0]     pi_full, pp_full, pd_full;
  logic signed [PROD_W-1:0]   pi2_r, pp2_r, pd2_r;
  logic signed [PROD_W-1:0]   pi_abs;
  logic signed [AP_W-1:0]     ap_nxt;
  logic                       pneg3_r, pneg4_r, pneg5_r, pneg6_r, pneg7_r;
  logic [PMAG_W-1:0]          pmag3_r, pmag4_r;
  logic signed [AP_W-1:0]     ap3_r, ap4_r, ap5_r, ap6_r, ap7_r;
  logic [PMAG_W+DIV125_M_W-1:0] qa_prod;
  logic [QA_W-1:0]            qa4_r;
  logic [PMAG_W-1:0]          r1;
  logic                       ge1;
  logic [QA_W-1:0]            a5_r, a6_r;
  logic [REM_W-1:0]           b5_r, b6_r;
  logic [F+4:0]               q2_prod;
  logic [M2_W-1:0]            q2e6_r;
  logic [R2_W-1:0]            r2;
  logic                       ge2;
  logic [M2_W-1:0]            frac;
  logic [MAG_W-1:0]           mag_nxt, mag7_r;

  // Whole front advances together unless the last stage is blocked by the queue
  assign en       = !vld_r[7] || q_ready;
  assign in_stall = !en;
  assign q_valid  = vld_r[7];
  assign q_data   = {pneg7_r, mag7_r, ap7_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[6:1], in_valid};
    end
  end

  // Remember the last accepted measurement
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (in_valid && en) begin
      prev_r <= in_data.measured_speed;
    end
  end

  // Error and measurement change
  always_comb begin
    err_nxt = $signed({1'b0, in_data.target_speed}) - $signed({1'b0, in_data.measured_speed});
    dm_nxt  = $signed({1'b0, in_data.measured_speed}) - $signed({1'b0, prev_r});
  end

  // Gain products
  always_comb begin
    pi_full = err1_r * $signed({1'b0, gains.gain_i});
    pp_full = err1_r * $signed({1'b0, gains.gain_p});
    pd_full = dm1_r * $signed({1'b0, gains.gain_d});
  end

  // Split sign and magnitude, combine proportional and derivative parts
  always_comb begin
    pi_abs = pi2_r[PROD_W-1] ? -pi2_r : pi2_r;
    ap_nxt = AP_W'(pp2_r) - (AP_W'(pd2_r) <<< 3) - (AP_W'(pd2_r) <<< 1);
  end

  // Coarse quotient by 125
  assign qa_prod = (PMAG_W+DIV125_M_W)'(pmag3_r) * (PMAG_W+DIV125_M_W)'(DIV125_M);

  // Correct quotient by 125, keep remainder
  always_comb begin
    r1  = pmag4_r - PMAG_W'(qa4_r) * PMAG_W'(INT_DIV);
    ge1 = r1 >= PMAG_W'(INT_DIV);
  end

  // Fraction part: floor(b * 2^(F-3) / 125)
  assign q2_prod = (F+5)'(b5_r) * (F+5)'(M2);

  always_comb begin
    r2      = (R2_W'(b6_r) << SH) - R2_W'(q2e6_r) * R2_W'(INT_DIV);
    ge2     = r2 >= R2_W'(INT_DIV);
    frac    = q2e6_r + M2_W'(ge2);
    mag_nxt = (MAG_W'(a6_r) << SH) + MAG_W'(frac);
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      err1_r  <= err_nxt;
      dm1_r   <= dm_nxt;

      pi2_r   <= pi_full[PROD_W-1:0];
      pp2_r   <= pp_full[PROD_W-1:0];
      pd2_r   <= pd_full[PROD_W-1:0];

      pneg3_r <= pi2_r[PROD_W-1];
      pmag3_r <= pi_abs[PMAG_W-1:0];
      ap3_r   <= ap_nxt;

      pneg4_r <= pneg3_r;
      pmag4_r <= pmag3_r;
      qa4_r   <= qa_prod[PMAG_W+DIV125_M_W-1:DIV125_SH];
      ap4_r   <= ap3_r;

      pneg5_r <= pneg4_r;
      a5_r    <= qa4_r + QA_W'(ge1);
      b5_r    <= ge1 ? REM_W'(r1 - PMAG_W'(INT_DIV)) : REM_W'(r1);
      ap5_r   <= ap4_r;

      pneg6_r <= pneg5_r;
      a6_r    <= a5_r;
      b6_r    <= b5_r;
      q2e6_r  <= q2_prod[F+4:7];
      ap6_r   <= ap5_r;

      pneg7_r <= pneg6_r;
      mag7_r  <= mag_nxt;
      ap7_r   <= ap6_r;
    end
  end

endmodule

>>> rtl/pidsc_queue.sv
module pidsc_queue #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Advance pointers with wrap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // Store beat
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/pidsc_back.sv
module pidsc_back #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       q_valid,
  output logic                                       q_ready,
  input  logic [FRACTION_BITS+pidsc_pkg::AP_W+16:0]  q_data,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output pidsc_pkg::out_item_t                       out_data
);
  import pidsc_pkg::*;

  localparam int F     = FRACTION_BITS;
  localparam int MAG_W = F + 16;
  localparam int IW    = F + 15;
  localparam int SW    = F + 18;
  localparam int S_W   = F + 8;
  localparam logic [63:0]          ILIM_U = 64'(INT_LIMIT) << F;
  localparam logic signed [SW-1:0] ILIM   = SW'(ILIM_U);
  localparam logic [S_W-1:0]       S_ONE  = S_W'(64'(DRV_DIV) << F);

  logic                       en, pop;
  logic [6:1]                 vld_r;

  logic                       q_neg;
  logic [MAG_W-1:0]           q_mag;
  logic signed [AP_W-1:0]     q_ap;

  logic signed [IW-1:0]       integ_r, integ_nxt;
  logic signed [SW-1:0]       imag, isum;
  logic signed [IW-1:0]       i1_r;
  logic signed [AP_W-1:0]     ap1_r;

  logic signed [SPEED_W-1:0]  ii;
  logic signed [31:0]         bsum;
  logic [B_W-1:0]             b2_r, b3_r;
  logic [F-1:0]               if2_r, if3_r, if4_r;

  logic [B_W+DIV100_M_W-1:0]  qb_prod;
  logic [QB_W-1:0]            qb3_r, qb4_r;
  logic [B_W-1:0]             rb;
  logic                       geb;
  logic [REM_W-1:0]           ra4_r;

  logic [S_W-1:0]             s_sum;
  logic                       s_carry, s_exact;
  logic signed [FULL_W-1:0]   fl_nxt, fl5_r;
  logic                       exact5_r;

  logic signed [FULL_W-1:0]   tr;
  logic                       sat_hi, sat_lo;
  out_item_t                  out_r;

  // Back pipeline moves unless the output register is held
  assign en        = !vld_r[6] || !out_stall;
  assign q_ready   = en;
  assign pop       = q_valid && en;
  assign out_valid = vld_r[6];
  assign out_data  = out_r;

  assign q_neg = q_data[MAG_W+AP_W];
  assign q_mag = q_data[MAG_W+AP_W-1:AP_W];
  assign q_ap  = $signed(q_data[AP_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:1], q_valid};
    end
  end

  // Accumulate integral and clamp to its limit
  always_comb begin
    imag = $signed(SW'(q_mag));
    isum = q_neg ? SW'(integ_r) - imag : SW'(integ_r) + imag;
    if (isum > ILIM) begin
      integ_nxt = IW'(ILIM);
    end else if (isum < -ILIM) begin
      integ_nxt = IW'(-ILIM);
    end else begin
      integ_nxt = IW'(isum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (pop) begin
      integ_r <= integ_nxt;
    end
  end

  // Biased numerator over 2^F: ap + 100 * integer part of integral
  always_comb begin
    ii   = i1_r[IW-1:F];
    bsum = 32'(ap1_r) + 32'(ii) * 32'sd100 + 32'(DRIVE_BIAS);
  end

  // Coarse quotient by 100
  assign qb_prod = (B_W+DIV100_M_W)'(b2_r) * (B_W+DIV100_M_W)'(DIV100_M);

  // Correct quotient by 100
  always_comb begin
    rb  = b3_r - B_W'(qb3_r) * B_W'(DRV_DIV);
    geb = rb >= B_W'(DRV_DIV);
  end

  // Fold remainder and integral fraction into the floor, flag exact results
  always_comb begin
    s_sum   = (S_W'(ra4_r) << F) + S_W'(if4_r) * S_W'(DRV_DIV);
    s_carry = s_sum >= S_ONE;
    s_exact = (s_sum == '0) || (s_sum == S_ONE);
    fl_nxt  = $signed(FULL_W'(qb4_r) - FULL_W'(DRIVE_BIAS_Q) + FULL_W'(s_carry));
  end

  // Round toward zero and saturate
  always_comb begin
    tr     = fl5_r + $signed(FULL_W'(fl5_r[FULL_W-1] && !exact5_r));
    sat_hi = tr > FULL_W'(DRIVE_MAX);
    sat_lo = tr < FULL_W'(DRIVE_MIN);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i1_r     <= integ_nxt;
      ap1_r    <= q_ap;

      b2_r     <= bsum[B_W-1:0];
      if2_r    <= i1_r[F-1:0];

      b3_r     <= b2_r;
      qb3_r    <= qb_prod[B_W+DIV100_M_W-1:DIV100_SH];
      if3_r    <= if2_r;

      qb4_r    <= qb3_r + QB_W'(geb);
      ra4_r    <= geb ? REM_W'(rb - B_W'(DRV_DIV)) : REM_W'(rb);
      if4_r    <= if3_r;

      fl5_r    <= fl_nxt;
      exact5_r <= s_exact;

      out_r.output_saturated <= sat_hi || sat_lo;
      if (sat_hi) begin
        out_r.drive_value <= DRIVE_MAX;
      end else if (sat_lo) begin
        out_r.drive_value <= DRIVE_MIN;
      end else begin
        out_r.drive_value <= tr[DRIVE_W-1:0];
      end
    end
  end

endmodule

>>> rtl/pid_speed_controller.sv
// Channel  Direction  Handshake            Beat payload
// in_      input      in_valid / in_stall    target_speed, measured_speed
// out_     output     out_valid / out_stall  drive_value, output_saturated
// cfg_     input      cfg_wr_en              cfg_index selects gain_p, gain_i, gain_d
//
// One beat per cycle sustained while out_stall is low; a beat accepted on an edge passes
// 7 front stages (the first loading on that edge), one queue slot and 6 back stages.
// The integral add and clamp is the longest feedback loop and closes in one back stage.
// rst_n (synchronous) empties both pipelines and the queue, clears integral and previous
// speed, and sets all gains to 10.
// out_stall holds the back pipeline only; the queue absorbs front results until it fills,
// then in_stall rises.
module pid_speed_controller #(
  parameter int FRACTION_BITS = 16,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  pidsc_pkg::in_item_t                    in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output pidsc_pkg::out_item_t                   out_data,
  input  logic                                   cfg_wr_en,
  input  logic [pidsc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [pidsc_pkg::GAIN_W-1:0]           cfg_wdata
);
  import pidsc_pkg::*;

  localparam int QW = FRACTION_BITS + AP_W + 17;

  gains_t          gains_r, gains_nxt;
  logic            fq_valid, fq_ready, bq_valid, bq_ready;
  logic [QW-1:0]   fq_data, bq_data;

  // Decode gain writes
  always_comb begin
    gains_nxt = gains_r;
    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_GAIN_P: gains_nxt.gain_p = cfg_wdata;
        REG_GAIN_I: gains_nxt.gain_i = cfg_wdata;
        REG_GAIN_D: gains_nxt.gain_d = cfg_wdata;
        default:    gains_nxt = gains_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r <= '{gain_p: GAIN_RESET, gain_i: GAIN_RESET, gain_d: GAIN_RESET};
    end else begin
      gains_r <= gains_nxt;
    end
  end

  pidsc_front #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .gains    (gains_r),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  pidsc_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (bq_valid),
    .pop_ready  (bq_ready),
    .pop_data   (bq_data)
  );

  pidsc_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (bq_valid),
    .q_ready   (bq_ready),
    .q_data    (bq_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/pidsc_checker.sv
module pidsc_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input pidsc_pkg::out_item_t out_data
);
  import pidsc_pkg::*;

  logic [7:0] pend_r;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;

  // Count beats accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 8'(in_beat) - 8'(out_beat);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_no_extra_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 8'd0)
    else $error("output beat without a pending input beat");

  a_sat_on_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.output_saturated |->
      (out_data.drive_value == DRIVE_MAX || out_data.drive_value == DRIVE_MIN))
    else $error("saturation flag set off the rails");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind pid_speed_controller pidsc_checker u_pidsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> tb/tb_pid_speed_controller.sv
`timescale 1ns / 1ps

module tb_pid_speed_controller;
  import pidsc_pkg::*;

  localparam int FRAC         = 16;
  localparam int DRAIN_CYCLES = 30;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SPEED_MAX    = (1 << SPEED_W) - 1;
  localparam int GAIN_MAX     = (1 << GAIN_W) - 1;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam longint ONE       = 64'sd1 <<< FRAC;
  localparam longint INTEG_LIM = longint'(INT_LIMIT) * ONE;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  in_item_t               in_data;
  logic                   out_valid;
  logic                   out_stall;
  out_item_t              out_data;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [GAIN_W-1:0]      cfg_wdata;

  // Controller state as the testbench tracks it
  logic [GAIN_W-1:0]  pred_gain_p;
  logic [GAIN_W-1:0]  pred_gain_i;
  logic [GAIN_W-1:0]  pred_gain_d;
  longint             pred_integral;
  logic [SPEED_W-1:0] pred_prev_speed;

  out_item_t drive_q[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  bit        tx_gaps = 1'b0;
  bit        rx_random = 1'b0;
  bit        hold_req = 1'b0;
  int        last_meas = 0;

  pid_speed_controller #(
    .FRACTION_BITS(FRAC)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d drive values still pending", $time, drive_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Mostly no gap, sometimes a few cycles, rarely a long one
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int clamp_speed(int v);
    if (v < 0) return 0;
    if (v > SPEED_MAX) return SPEED_MAX;
    return v;
  endfunction

  // Advance the controller by one sample and return the expected drive beat
  function automatic out_item_t predict_drive(in_item_t it);
    longint    err;
    longint    dmeas;
    longint    sum;
    longint    drv;
    out_item_t res;
    err   = longint'(it.target_speed) - longint'(it.measured_speed);
    dmeas = longint'(it.measured_speed) - longint'(pred_prev_speed);

    // Integrate, then clamp
    pred_integral += (err * longint'(pred_gain_i) * ONE) / 1000;
    if (pred_integral > INTEG_LIM) pred_integral = INTEG_LIM;
    else if (pred_integral < -INTEG_LIM) pred_integral = -INTEG_LIM;

    // Exact sum, truncated toward zero by signed division
    sum = err * longint'(pred_gain_p) * ONE + 100 * pred_integral
        - 10 * dmeas * longint'(pred_gain_d) * ONE;
    drv = sum / (100 * ONE);

    res.output_saturated = 1'b0;
    if (drv > longint'(DRIVE_MAX)) begin
      drv = longint'(DRIVE_MAX);
      res.output_saturated = 1'b1;
    end else if (drv < longint'(DRIVE_MIN)) begin
      drv = longint'(DRIVE_MIN);
      res.output_saturated = 1'b1;
    end
    res.drive_value = drv[DRIVE_W-1:0];
    pred_prev_speed = it.measured_speed;
    return res;
  endfunction

  // Check each drive beat against the oldest prediction
  always @(posedge clk) begin : check_drive
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (drive_q.size() == 0) begin
        $display("%0t: unexpected beat: drive_value %0d saturated %0b", $time,
                 out_data.drive_value, out_data.output_saturated);
        mismatch_count++;
      end else begin
        want = drive_q.pop_front();
        if (out_data.drive_value !== want.drive_value) begin
          $display("%0t: drive_value expected %0d actual %0d", $time,
                   want.drive_value, out_data.drive_value);
          mismatch_count++;
        end
        if (out_data.output_saturated !== want.output_saturated) begin
          $display("%0t: output_saturated expected %0b actual %0b", $time,
                   want.output_saturated, out_data.output_saturated);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver stall: random runs, or one long hold when asked
  initial begin : rx_stall
    int run;
    run = 0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        run = LONG_HOLD;
      end
      if (run > 0) begin
        out_stall <= 1'b1;
        run--;
      end else if (rx_random) begin
        run = rand_gap();
        out_stall <= (run > 0);
        if (run > 0) run--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic idle_in(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Offer one sample, wait for it to be taken, record its prediction
  task automatic send_speeds(int tgt, int meas);
    in_item_t it;
    int       gap;
    gap = tx_gaps ? rand_gap() : 0;
    if (gap > 0) idle_in(gap);
    it.target_speed   = tgt[SPEED_W-1:0];
    it.measured_speed = meas[SPEED_W-1:0];
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    drive_q.push_back(predict_drive(it));
    last_meas = meas;
    @(negedge clk);
  endtask

  // Random sample: wide jumps, closed-loop tracking, or full-scale corners
  task automatic send_random();
    int r;
    int tgt;
    int meas;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      tgt  = $urandom_range(0, SPEED_MAX);
      meas = $urandom_range(0, SPEED_MAX);
    end else if (r < 90) begin
      meas = clamp_speed(last_meas + int'($urandom_range(0, 200)) - 100);
      tgt  = clamp_speed(meas + int'($urandom_range(0, 2000)) - 1000);
    end else begin
      tgt  = $urandom_range(0, 1) ? SPEED_MAX : 0;
      meas = $urandom_range(0, 1) ? SPEED_MAX : 0;
    end
    send_speeds(tgt, meas);
  endtask

  // Drop valid, wait for all predictions to drain, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write all gains; a write to the unused index goes first and must be dropped
  task automatic set_gains(int gp, int gi, int gd);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_wdata <= GAIN_W'($urandom);
    @(negedge clk);
    cfg_index <= REG_GAIN_P;
    cfg_wdata <= gp[GAIN_W-1:0];
    @(negedge clk);
    cfg_index <= REG_GAIN_I;
    cfg_wdata <= gi[GAIN_W-1:0];
    @(negedge clk);
    cfg_index <= REG_GAIN_D;
    cfg_wdata <= gd[GAIN_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    pred_gain_p = gp[GAIN_W-1:0];
    pred_gain_i = gi[GAIN_W-1:0];
    pred_gain_d = gd[GAIN_W-1:0];
  endtask

  function automatic int pick_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 30) return GAIN_MAX;
    return $urandom_range(0, GAIN_MAX);
  endfunction

  // Field corners, unit errors, both integral clamps and all-zero gains
  task automatic test_directed();
    rx_random = 1'b1;
    send_speeds(0, 0);
    send_speeds(SPEED_MAX, 0);
    send_speeds(0, SPEED_MAX);
    send_speeds(SPEED_MAX, SPEED_MAX);
    send_speeds('h5555, 'h2AAA);
    send_speeds('h2AAA, 'h5555);
    send_speeds(0, 1);
    send_speeds(1, 0);
    wait_idle();
    set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
    // push the integral into its upper clamp and hold it there
    repeat (3) send_speeds(SPEED_MAX, 0);
    // full-scale measurement step, then the lower clamp
    repeat (3) send_speeds(0, SPEED_MAX);
    send_speeds(SPEED_MAX, SPEED_MAX);
    send_speeds(0, 0);
    wait_idle();
    set_gains(0, 0, 0);
    send_speeds(SPEED_MAX, 0);
    send_speeds(0, SPEED_MAX);
    wait_idle();
  endtask

  // Stall the output for a long stretch while samples keep coming
  task automatic test_backpressure();
    set_gains(pick_gain(), pick_gain(), pick_gain());
    tx_gaps   = 1'b0;
    rx_random = 1'b1;
    hold_req  = 1'b1;
    repeat (60) send_random();
    wait_idle();
  endtask

  // Stop sending until every drive value is back, then resume
  task automatic test_sender_pause();
    tx_gaps   = 1'b1;
    rx_random = 1'b1;
    repeat (20) send_random();
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(negedge clk);
    repeat (20) send_random();
    wait_idle();
  endtask

  // Random traffic over a sequence of gain settings and idle patterns
  task automatic test_gain_sweep(int phases, int per_phase);
    for (int k = 0; k < phases; k++) begin
      case (k)
        0:       set_gains(GAIN_RESET, GAIN_RESET, GAIN_RESET);
        1:       set_gains(GAIN_MAX, 0, 0);
        2:       set_gains(0, GAIN_MAX, 0);
        3:       set_gains(0, 0, GAIN_MAX);
        4:       set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
        5:       set_gains(1, 1, 1);
        default: set_gains(pick_gain(), pick_gain(), pick_gain());
      endcase
      tx_gaps   = (k % 3 != 0);
      rx_random = (k % 3 != 0) && (k % 2 == 0 || $urandom_range(0, 1));
      repeat (per_phase) send_random();
      wait_idle();
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    pred_gain_p     = GAIN_RESET;
    pred_gain_i     = GAIN_RESET;
    pred_gain_d     = GAIN_RESET;
    pred_integral   = 0;
    pred_prev_speed = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_backpressure();
    test_sender_pause();
    test_gain_sweep(11, 130);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
